### hw/rtl/mstk_pkg.sv
`default_nettype none

package mstk_pkg;

  // fixed field widths
  localparam int CMD_W       = 3;
  localparam int VAL_W       = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 9;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH     = 3'd0,
    CMD_POP      = 3'd1,
    CMD_TOP      = 3'd2,
    CMD_PEEK_MAX = 3'd3,
    CMD_POP_MAX  = 3'd4
  } cmd_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/mstk_if.sv
`default_nettype none

// command channel
interface mstk_cmd_if;
  import mstk_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [VAL_W-1:0] push_value;

  modport source (output valid, cmd, push_value, input ready);
  modport sink   (input valid, cmd, push_value, output ready);
endinterface

// result channel
interface mstk_res_if;
  import mstk_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] result_value;
  logic [STATUS_W-1:0]     status;
  logic [COUNT_OUT_W-1:0]  entry_count;

  modport source (output valid, result_value, status, entry_count, input ready);
  modport sink   (input valid, result_value, status, entry_count, output ready);
endinterface

`default_nettype wire

### hw/rtl/max_stack_top.sv
`default_nettype none

// channel   | dir | transaction
// ----------+-----+----------------------------------------------------
// in_cmd    | in  | cmd (3b), push_value (32b signed)
// out_res   | out | result_value (32b signed), status (2b), entry_count (9b)
//
// One command is processed at a time; a single-port-read stack memory and one
// signed comparator are reused under a small sequencer.
// Push writes the entry directly; pop and top read the top entry. Peek max scans
// every entry from the top down; pop max then shifts the entries above the maximum
// down by one, one memory read per cycle during the scan and the shift.
// A finished result sits in the output register; the next command is taken
// while it waits. Reset clears the count; no clearing pass over the memory.

module max_stack_top #(
  parameter int DEPTH = 256
) (
  input  wire             clk,
  input  wire             rst_n,
  mstk_cmd_if.sink        in_cmd,
  mstk_res_if.source      out_res
);
  import mstk_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;

  // stack memory
  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_data_r;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [VAL_W-1:0] wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;

  // control state
  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload state
  cmd_t             cmd_r, cmd_nxt;
  logic [AW-1:0]    scan_idx_r, scan_idx_nxt;
  logic [VAL_W-1:0] best_val_r, best_val_nxt;
  logic [AW-1:0]    best_idx_r, best_idx_nxt;
  logic             first_r, first_nxt;
  logic [AW-1:0]    src_r, src_nxt;
  logic [VAL_W-1:0] res_val_r, res_val_nxt;
  status_t          res_st_r, res_st_nxt;
  logic [VAL_W-1:0] out_val_r, out_val_nxt;
  status_t          out_st_r, out_st_nxt;
  logic [COUNT_OUT_W-1:0] out_cnt_r, out_cnt_nxt;

  // derived count values
  logic [CW-1:0]    cnt_m1;
  logic [AW-1:0]    top_idx;
  logic             full;
  logic             empty;
  logic [EW-1:0]    cnt_ext;
  logic             take;
  logic [VAL_W-1:0] best_v;
  logic [AW-1:0]    best_i;

  assign cnt_m1  = count_r - CW'(1);
  assign top_idx = cnt_m1[AW-1:0];
  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign cnt_ext = EW'(count_r);

  // shared signed comparator for the maximum scan
  assign take   = first_r || ($signed(rd_data_r) > $signed(best_val_r));
  assign best_v = take ? rd_data_r : best_val_r;
  assign best_i = take ? scan_idx_r : best_idx_r;

  // memory ports, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    scan_idx_r <= scan_idx_nxt;
    best_val_r <= best_val_nxt;
    best_idx_r <= best_idx_nxt;
    first_r    <= first_nxt;
    src_r      <= src_nxt;
    res_val_r  <= res_val_nxt;
    res_st_r   <= res_st_nxt;
    out_val_r  <= out_val_nxt;
    out_st_r   <= out_st_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    cmd_nxt       = cmd_r;
    scan_idx_nxt  = scan_idx_r;
    best_val_nxt  = best_val_r;
    best_idx_nxt  = best_idx_r;
    first_nxt     = first_r;
    src_nxt       = src_r;
    res_val_nxt   = res_val_r;
    res_st_nxt    = res_st_r;
    out_val_nxt   = out_val_r;
    out_st_nxt    = out_st_r;
    out_cnt_nxt   = out_cnt_r;
    in_cmd.ready  = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = '0;

    // output register drains independently
    if (out_valid_r && out_res.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        in_cmd.ready = 1'b1;
        if (in_cmd.valid) begin
          cmd_nxt     = cmd_t'(in_cmd.cmd);
          res_val_nxt = '0;
          res_st_nxt  = ST_OK;
          state_nxt   = S_RESP;
          case (cmd_t'(in_cmd.cmd))
            CMD_PUSH: begin
              if (full) begin
                res_st_nxt = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = count_r[AW-1:0];
                wr_data   = in_cmd.push_value;
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_POP, CMD_TOP, CMD_PEEK_MAX, CMD_POP_MAX: begin
              if (empty) begin
                res_st_nxt = ST_EMPTY;
              end else begin
                rd_en        = 1'b1;
                rd_addr      = top_idx;
                scan_idx_nxt = top_idx;
                first_nxt    = 1'b1;
                if (cmd_t'(in_cmd.cmd) inside {CMD_POP, CMD_TOP}) begin
                  state_nxt = S_READ;
                end else begin
                  state_nxt = S_SCAN;
                end
                if (cmd_t'(in_cmd.cmd) == CMD_POP) begin
                  count_nxt = cnt_m1;
                end
              end
            end
            default: ;
          endcase
        end
      end

      // top entry arrives from memory
      S_READ: begin
        res_val_nxt = rd_data_r;
        state_nxt   = S_RESP;
      end

      // walk down from the top, keep the top-most maximum
      S_SCAN: begin
        best_val_nxt = best_v;
        best_idx_nxt = best_i;
        first_nxt    = 1'b0;
        if (scan_idx_r == '0) begin
          res_val_nxt = best_v;
          state_nxt   = S_RESP;
          if (cmd_r == CMD_POP_MAX) begin
            count_nxt = cnt_m1;
            if (CW'(best_i) < cnt_m1) begin
              rd_en     = 1'b1;
              rd_addr   = best_i + AW'(1);
              src_nxt   = best_i + AW'(1);
              state_nxt = S_SHIFT;
            end
          end
        end else begin
          rd_en        = 1'b1;
          rd_addr      = scan_idx_r - AW'(1);
          scan_idx_nxt = scan_idx_r - AW'(1);
        end
      end

      // close the gap: entry at src moves down by one
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = src_r - AW'(1);
        wr_data = rd_data_r;
        if (CW'(src_r) < count_r) begin
          rd_en   = 1'b1;
          rd_addr = src_r + AW'(1);
          src_nxt = src_r + AW'(1);
        end else begin
          state_nxt = S_RESP;
        end
      end

      // hand the result to the output register once it is free
      S_RESP: begin
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_st_nxt    = res_st_r;
          out_cnt_nxt   = cnt_ext[COUNT_OUT_W-1:0];
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result channel
  assign out_res.valid        = out_valid_r;
  assign out_res.result_value = out_val_r;
  assign out_res.status       = out_st_r;
  assign out_res.entry_count  = out_cnt_r;

`ifndef SYNTHESIS
  // count stays within the stack depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("stack count above depth");

  // accepted push with room grows the count by one
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_cmd.valid && in_cmd.ready && cmd_t'(in_cmd.cmd) == CMD_PUSH && !full)
    |=> count_r == $past(count_r) + CW'(1))
    else $error("push did not grow the count");

  // shift never writes below the bottom entry
  a_shift_src: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> src_r != '0)
    else $error("shift source at bottom");

  // full status only when the stack is at depth
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && res_st_r == ST_FULL) |-> full)
    else $error("full status without a full stack");

  // a new result is loaded only when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res.ready) |=> out_valid_r && $stable(out_val_r))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
